>>> rtl/rts_pkg.sv
`default_nettype none

package rts_pkg;

    localparam int DIVIDEND_W = 18;
    localparam int DIVISOR_W  = 10;
    localparam int QUOT_W     = 18;
    localparam int DIV_CNT_W  = $clog2(QUOT_W);

    localparam int WHOLE_NOTE_NUM = 4 * 60 * 1000;
    localparam int DEFAULT_TEMPO  = 63;

    localparam logic [DIVIDEND_W-1:0] WHOLE_NUM     = DIVIDEND_W'(WHOLE_NOTE_NUM);
    localparam logic [DIVIDEND_W-1:0] WHOLE_DEFAULT =
        DIVIDEND_W'(WHOLE_NOTE_NUM / DEFAULT_TEMPO);
    localparam logic [DIVISOR_W-1:0]  TEMPO_DEFAULT = DIVISOR_W'(DEFAULT_TEMPO);
    localparam logic [DIVISOR_W-1:0]  DIVIDER_DEFAULT = DIVISOR_W'(4);
    localparam logic [DIVISOR_W-1:0]  NUMBER_MAX    = DIVISOR_W'(999);
    localparam logic [2:0]            OCTAVE_DEFAULT = 3'd6;
    localparam logic [7:0]            GAP_RESET     = 8'd10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;

    localparam logic [11:0] TONE_TABLE [0:47] = '{
        12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
        12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494,
        12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
        12'd740,  12'd784,  12'd831,  12'd880,  12'd932,  12'd988,
        12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
        12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976,
        12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
        12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951
    };

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_res_t;

    function automatic logic [11:0] tone_of(input logic [5:0] k);
        logic [5:0] kc;
        kc = (k > 6'd47) ? 6'd47 : k;
        return TONE_TABLE[kc];
    endfunction

    function automatic logic [3:0] letter_index(input logic [7:0] c);
        logic [3:0] idx;
        unique case (c)
            CH_C:    idx = 4'd1;
            CH_D:    idx = 4'd3;
            CH_E:    idx = 4'd5;
            CH_F:    idx = 4'd6;
            CH_G:    idx = 4'd8;
            CH_A:    idx = 4'd10;
            CH_B:    idx = 4'd12;
            default: idx = 4'd0;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rtttl_tone_sequencer_unit.sv
// Channel   Signals                                    Direction
// input     in_valid/in_ready, text_byte, new_tune      in
// output    out_valid/out_ready, tone_hz, length_ms,    out
//           last_of_run
// config    cfg_valid/cfg_ready, gap_ms                 in
//
// One byte at a time: a header or note byte is parsed in S_PARSE, and the next byte
// is taken only once the sequencer is back in S_IDLE. A byte that ends a tempo or
// closes a note adds one pass of the shared bit-serial divider; a note then emits a tone and a gap result.
// Reset restores the default tune settings and a gap of 10 ms.
// A held output stalls the sequencer only when the next result is due.
`default_nettype none

module rtttl_tone_sequencer_unit
    import rts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_byte,
    input  wire logic        new_tune,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [11:0]      tone_hz,
    output logic [18:0]      length_ms,
    output logic             last_of_run,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  gap_ms
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_SIL       = 7'b0000010,
        S_PARSE     = 7'b0000100,
        S_DIV_TEMPO = 7'b0001000,
        S_DIV_NOTE  = 7'b0010000,
        S_EMIT_NOTE = 7'b0100000,
        S_EMIT_GAP  = 7'b1000000
    } ctrl_t;

    typedef enum logic [15:0] {
        PH_NAME    = 16'h0001,
        PH_D_KEY   = 16'h0002,
        PH_D_EQ    = 16'h0004,
        PH_D_NUM   = 16'h0008,
        PH_O_KEY   = 16'h0010,
        PH_O_EQ    = 16'h0020,
        PH_O_VAL   = 16'h0040,
        PH_O_END   = 16'h0080,
        PH_B_KEY   = 16'h0100,
        PH_B_EQ    = 16'h0200,
        PH_B_NUM   = 16'h0400,
        PH_N_DIV   = 16'h0800,
        PH_N_SHARP = 16'h1000,
        PH_N_DOT   = 16'h2000,
        PH_N_OCT   = 16'h4000,
        PH_N_DOT2  = 16'h8000
    } phase_t;

    ctrl_t                 state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [DIVISOR_W-1:0]  def_div_reg, def_div_next;
    logic [2:0]            def_oct_reg, def_oct_next;
    logic [DIVIDEND_W-1:0] whole_reg, whole_next;
    logic [DIVISOR_W-1:0]  acc_reg, acc_next;
    logic [3:0]            idx_reg, idx_next;
    logic [2:0]            oct_reg, oct_next;
    logic                  dot_reg, dot_next;
    logic [7:0]            gap_reg, gap_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  out_valid_reg, out_valid_next;
    logic [11:0]           hz_reg, hz_next;
    logic [18:0]           len_reg, len_next;
    logic                  last_reg, last_next;

    div_req_t              div_req;
    div_res_t              div_res;

    logic                  slot_free;
    logic                  load_out;
    logic                  restart;
    logic                  close;
    logic                  is_digit;
    logic                  is_oct_digit;
    logic                  note_open;
    logic [13:0]           acc_prod;
    logic [DIVISOR_W-1:0]  acc_sat;
    logic [DIVISOR_W-1:0]  note_div;
    logic [DIVISOR_W-1:0]  bpm;
    logic [1:0]            oct_sel;
    logic [5:0]            tone_k;
    logic [11:0]           note_hz;
    logic [18:0]           note_len;

    rts_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign tone_hz     = hz_reg;
    assign length_ms   = len_reg;
    assign last_of_run = last_reg;

    assign slot_free    = !out_valid_reg || out_ready;
    assign is_digit     = (byte_reg >= CH_0) && (byte_reg <= CH_9);
    assign is_oct_digit = (byte_reg >= CH_4) && (byte_reg <= CH_7);
    assign note_open    = (phase_reg == PH_N_SHARP) || (phase_reg == PH_N_DOT) ||
                          (phase_reg == PH_N_OCT) || (phase_reg == PH_N_DOT2);

    assign acc_prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                      {10'b0, byte_reg[3:0]};
    assign acc_sat  = (acc_prod > {4'b0, NUMBER_MAX}) ? NUMBER_MAX : acc_prod[DIVISOR_W-1:0];

    always_comb
    begin
        note_div = (acc_reg != '0) ? acc_reg : def_div_reg;
        if (note_div == '0)
        begin
            note_div = DIVIDER_DEFAULT;
        end
    end

    assign bpm      = (acc_reg != '0) ? acc_reg : TEMPO_DEFAULT;
    assign oct_sel  = (oct_reg >= 3'd4) ? oct_reg[1:0] : 2'd2;
    assign tone_k   = 6'({oct_sel, 3'b000}) + 6'({oct_sel, 2'b00}) + {2'b00, idx_reg} - 6'd1;
    assign note_hz  = (idx_reg != '0) ? tone_of(tone_k) : 12'd0;
    assign note_len = {1'b0, div_res.quotient} +
                      (dot_reg ? {2'b00, div_res.quotient[QUOT_W-1:1]} : 19'd0);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        def_div_next = def_div_reg;
        def_oct_next = def_oct_reg;
        whole_next   = whole_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        oct_next     = oct_reg;
        dot_next     = dot_reg;
        byte_next    = byte_reg;
        gap_next     = cfg_valid ? gap_ms : gap_reg;
        div_req      = '0;
        load_out     = 1'b0;
        hz_next      = hz_reg;
        len_next     = len_reg;
        last_next    = last_reg;
        restart      = 1'b0;
        close        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = text_byte;
                    if (new_tune)
                    begin
                        restart    = 1'b1;
                        state_next = S_SIL;
                    end
                    else
                    begin
                        state_next = S_PARSE;
                    end
                end
            end
            S_SIL:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    hz_next    = '0;
                    len_next   = '0;
                    last_next  = 1'b1;
                    state_next = S_PARSE;
                end
            end
            S_PARSE:
            begin
                state_next = S_IDLE;
                if (byte_reg == CH_NUL)
                begin
                    if (note_open)
                    begin
                        close = 1'b1;
                    end
                    else
                    begin
                        restart = 1'b1;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_NAME:
                        begin
                            if (byte_reg == CH_COLON)
                            begin
                                phase_next = PH_D_KEY;
                            end
                        end
                        PH_D_KEY:
                        begin
                            if (byte_reg == CH_D)
                            begin
                                phase_next = PH_D_EQ;
                            end
                            else
                            begin
                                phase_next = PH_O_KEY;
                                state_next = S_PARSE;
                            end
                        end
                        PH_D_EQ:
                        begin
                            acc_next   = '0;
                            phase_next = PH_D_NUM;
                        end
                        PH_D_NUM:
                        begin
                            if (is_digit)
                            begin
                                acc_next = acc_sat;
                            end
                            else
                            begin
                                if (acc_reg != '0)
                                begin
                                    def_div_next = acc_reg;
                                end
                                acc_next   = '0;
                                phase_next = PH_O_KEY;
                            end
                        end
                        PH_O_KEY:
                        begin
                            if (byte_reg == CH_O)
                            begin
                                phase_next = PH_O_EQ;
                            end
                            else
                            begin
                                phase_next = PH_B_KEY;
                                state_next = S_PARSE;
                            end
                        end
                        PH_O_EQ:
                        begin
                            phase_next = PH_O_VAL;
                        end
                        PH_O_VAL:
                        begin
                            if (is_oct_digit)
                            begin
                                def_oct_next = byte_reg[2:0];
                            end
                            phase_next = PH_O_END;
                        end
                        PH_O_END:
                        begin
                            phase_next = PH_B_KEY;
                        end
                        PH_B_KEY:
                        begin
                            if (byte_reg == CH_B)
                            begin
                                phase_next = PH_B_EQ;
                            end
                            else
                            begin
                                whole_next = WHOLE_DEFAULT;
                                acc_next   = '0;
                                phase_next = PH_N_DIV;
                                state_next = S_PARSE;
                            end
                        end
                        PH_B_EQ:
                        begin
                            acc_next   = '0;
                            phase_next = PH_B_NUM;
                        end
                        PH_B_NUM:
                        begin
                            if (is_digit)
                            begin
                                acc_next = acc_sat;
                            end
                            else
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = WHOLE_NUM;
                                div_req.divisor  = bpm;
                                acc_next         = '0;
                                phase_next       = PH_N_DIV;
                                state_next       = S_DIV_TEMPO;
                            end
                        end
                        PH_N_DIV:
                        begin
                            if (is_digit)
                            begin
                                acc_next = acc_sat;
                            end
                            else
                            begin
                                idx_next   = letter_index(byte_reg);
                                oct_next   = def_oct_reg;
                                dot_next   = 1'b0;
                                phase_next = PH_N_SHARP;
                            end
                        end
                        PH_N_SHARP:
                        begin
                            phase_next = PH_N_DOT;
                            if (byte_reg == CH_SHARP)
                            begin
                                if (idx_reg != '0)
                                begin
                                    idx_next = idx_reg + 4'd1;
                                end
                            end
                            else
                            begin
                                state_next = S_PARSE;
                            end
                        end
                        PH_N_DOT:
                        begin
                            phase_next = PH_N_OCT;
                            if (byte_reg == CH_DOT)
                            begin
                                dot_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_PARSE;
                            end
                        end
                        PH_N_OCT:
                        begin
                            if (is_digit)
                            begin
                                oct_next   = is_oct_digit ? byte_reg[2:0] : def_oct_reg;
                                phase_next = PH_N_DOT2;
                            end
                            else
                            begin
                                close = 1'b1;
                            end
                        end
                        PH_N_DOT2:
                        begin
                            if ((byte_reg == CH_DOT) && !dot_reg)
                            begin
                                dot_next = 1'b1;
                            end
                            else
                            begin
                                close = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_NAME;
                        end
                    endcase
                end
                if (close)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = whole_reg;
                    div_req.divisor  = note_div;
                    acc_next         = '0;
                    phase_next       = PH_N_DIV;
                    state_next       = S_DIV_NOTE;
                end
            end
            S_DIV_TEMPO:
            begin
                if (div_res.done)
                begin
                    whole_next = div_res.quotient;
                    state_next = S_IDLE;
                end
            end
            S_DIV_NOTE:
            begin
                if (div_res.done)
                begin
                    state_next = S_EMIT_NOTE;
                end
            end
            S_EMIT_NOTE:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    hz_next    = note_hz;
                    len_next   = note_len;
                    last_next  = 1'b0;
                    state_next = S_EMIT_GAP;
                end
            end
            S_EMIT_GAP:
            begin
                if (slot_free)
                begin
                    load_out  = 1'b1;
                    hz_next   = '0;
                    len_next  = {11'b0, gap_reg};
                    last_next = 1'b1;
                    priority if (byte_reg == CH_NUL)
                    begin
                        restart    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (byte_reg == CH_COMMA)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PARSE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (restart)
        begin
            phase_next   = PH_NAME;
            def_div_next = DIVIDER_DEFAULT;
            def_oct_next = OCTAVE_DEFAULT;
            whole_next   = WHOLE_DEFAULT;
            acc_next     = '0;
            idx_next     = '0;
            oct_next     = OCTAVE_DEFAULT;
            dot_next     = 1'b0;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_NAME;
            def_div_reg   <= DIVIDER_DEFAULT;
            def_oct_reg   <= OCTAVE_DEFAULT;
            whole_reg     <= WHOLE_DEFAULT;
            acc_reg       <= '0;
            idx_reg       <= '0;
            oct_reg       <= OCTAVE_DEFAULT;
            dot_reg       <= 1'b0;
            gap_reg       <= GAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            def_div_reg   <= def_div_next;
            def_oct_reg   <= def_oct_next;
            whole_reg     <= whole_next;
            acc_reg       <= acc_next;
            idx_reg       <= idx_next;
            oct_reg       <= oct_next;
            dot_reg       <= dot_next;
            gap_reg       <= gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        hz_reg   <= hz_next;
        len_reg  <= len_next;
        last_reg <= last_next;
    end

`ifndef SYNTHESIS
    a_div_start_from_parse: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (state_reg == S_PARSE))
        else $error("divider started outside parse");

    a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !div_res.busy)
        else $error("byte transfer while divider busy");

    a_note_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV_NOTE) && div_res.done) |=> (state_reg == S_EMIT_NOTE))
        else $error("note length lost after divide");

    a_note_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT_NOTE) && slot_free) |=>
            (out_valid_reg && !last_reg && (state_reg == S_EMIT_GAP)))
        else $error("note result marked last or gap skipped");
`endif

endmodule

`default_nettype wire

>>> rtl/rts_serial_div.sv
`default_nettype none

module rts_serial_div
    import rts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_res_t      res
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [QUOT_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(QUOT_W - 1);
            rem_next  = '0;
            dsr_next  = req.divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[QUOT_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign res.busy     = busy_reg;
    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

`default_nettype wire

>>> tb/sv/rtttl_tone_checker.sv
module rtttl_tone_checker
    import rts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  text_byte,
    input  wire logic        new_tune,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [11:0] tone_hz,
    input  wire logic [18:0] length_ms,
    input  wire logic        last_of_run,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  gap_ms,
    output int               errors,
    output int               pending
);

    localparam int KEYS_PER_OCTAVE = 12;
    localparam int REPORT_MAX      = 10;

    typedef enum logic [3:0] {
        ST_NAME,
        ST_DIV_KEY,
        ST_DIV_EQ,
        ST_DIV_NUM,
        ST_OCT_KEY,
        ST_OCT_EQ,
        ST_OCT_VAL,
        ST_OCT_END,
        ST_BPM_KEY,
        ST_BPM_EQ,
        ST_BPM_NUM,
        ST_NOTE_DIV,
        ST_NOTE_SHARP,
        ST_NOTE_DOT,
        ST_NOTE_OCT,
        ST_NOTE_DOT2
    } parse_state_t;

    typedef struct packed {
        logic [11:0] hz;
        logic [18:0] ms;
        logic        last;
    } tone_cmd_t;

    parse_state_t  phase;
    logic [9:0]    dflt_div;
    logic [2:0]    dflt_oct;
    logic [17:0]   whole_ms;
    logic [9:0]    acc;
    logic [3:0]    note_idx;
    logic [2:0]    note_oct;
    logic          dotted;
    logic [7:0]    gap;

    tone_cmd_t     step_cmds[$];
    tone_cmd_t     tone_cmds_due[$];
    tone_cmd_t     want;
    int            err_count;

    function automatic void restart_tune();
        phase    = ST_NAME;
        dflt_div = DIVIDER_DEFAULT;
        dflt_oct = OCTAVE_DEFAULT;
        whole_ms = WHOLE_DEFAULT;
        acc      = '0;
        note_idx = '0;
        note_oct = OCTAVE_DEFAULT;
        dotted   = 1'b0;
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        int v;
        v = int'(acc) * 10 + (int'(c) - int'(CH_0));
        acc = (v > int'(NUMBER_MAX)) ? NUMBER_MAX : 10'(v);
    endfunction

    function automatic void push_cmd(input logic [11:0] hz, input logic [18:0] ms);
        tone_cmd_t cmd;
        cmd.hz   = hz;
        cmd.ms   = ms;
        cmd.last = 1'b0;
        step_cmds.push_back(cmd);
    endfunction

    function automatic void play_note();
        int div;
        int dur;
        int oct;
        int k;
        logic [11:0] hz;
        div = (acc != 0) ? int'(acc) : int'(dflt_div);
        if (div == 0)
            div = int'(DIVIDER_DEFAULT);
        dur = int'(whole_ms) / div;
        if (dotted)
            dur += dur / 2;
        hz = '0;
        if (note_idx != 0)
        begin
            oct = (note_oct >= 3'd4) ? ((int'(note_oct) - 4) & 3) : 2;
            k = oct * KEYS_PER_OCTAVE + int'(note_idx) - 1;
            if (k > 47)
                k = 47;
            hz = TONE_TABLE[k];
        end
        push_cmd(hz, 19'(dur));
        push_cmd('0, 19'(gap));
        acc = '0;
    endfunction

    function automatic void predict_byte(input logic [7:0] c, input logic nt);
        bit again;
        int bpm;
        step_cmds.delete();
        if (nt)
        begin
            restart_tune();
            push_cmd('0, '0);
        end
        if (c == CH_NUL)
        begin
            if (phase >= ST_NOTE_SHARP)
                play_note();
            restart_tune();
        end
        else
        begin
            again = 1'b1;
            while (again)
            begin
                again = 1'b0;
                case (phase)
                    ST_NAME:
                        if (c == CH_COLON)
                            phase = ST_DIV_KEY;
                    ST_DIV_KEY:
                        if (c == CH_D)
                            phase = ST_DIV_EQ;
                        else
                        begin
                            phase = ST_OCT_KEY;
                            again = 1'b1;
                        end
                    ST_DIV_EQ:
                    begin
                        acc   = '0;
                        phase = ST_DIV_NUM;
                    end
                    ST_DIV_NUM:
                        if (is_num(c))
                            take_digit(c);
                        else
                        begin
                            if (acc != 0)
                                dflt_div = acc;
                            acc   = '0;
                            phase = ST_OCT_KEY;
                        end
                    ST_OCT_KEY:
                        if (c == CH_O)
                            phase = ST_OCT_EQ;
                        else
                        begin
                            phase = ST_BPM_KEY;
                            again = 1'b1;
                        end
                    ST_OCT_EQ:
                        phase = ST_OCT_VAL;
                    ST_OCT_VAL:
                    begin
                        if (c >= CH_4 && c <= CH_7)
                            dflt_oct = 3'(c - CH_0);
                        phase = ST_OCT_END;
                    end
                    ST_OCT_END:
                        phase = ST_BPM_KEY;
                    ST_BPM_KEY:
                        if (c == CH_B)
                            phase = ST_BPM_EQ;
                        else
                        begin
                            whole_ms = WHOLE_DEFAULT;
                            acc      = '0;
                            phase    = ST_NOTE_DIV;
                            again    = 1'b1;
                        end
                    ST_BPM_EQ:
                    begin
                        acc   = '0;
                        phase = ST_BPM_NUM;
                    end
                    ST_BPM_NUM:
                        if (is_num(c))
                            take_digit(c);
                        else
                        begin
                            bpm      = (acc != 0) ? int'(acc) : DEFAULT_TEMPO;
                            whole_ms = 18'(WHOLE_NOTE_NUM / bpm);
                            acc      = '0;
                            phase    = ST_NOTE_DIV;
                        end
                    ST_NOTE_DIV:
                        if (is_num(c))
                            take_digit(c);
                        else
                        begin
                            case (c)
                                CH_C:    note_idx = 4'd1;
                                CH_D:    note_idx = 4'd3;
                                CH_E:    note_idx = 4'd5;
                                CH_F:    note_idx = 4'd6;
                                CH_G:    note_idx = 4'd8;
                                CH_A:    note_idx = 4'd10;
                                CH_B:    note_idx = 4'd12;
                                default: note_idx = 4'd0;
                            endcase
                            note_oct = dflt_oct;
                            dotted   = 1'b0;
                            phase    = ST_NOTE_SHARP;
                        end
                    ST_NOTE_SHARP:
                    begin
                        if (c == CH_SHARP)
                        begin
                            if (note_idx != 0)
                                note_idx = note_idx + 4'd1;
                        end
                        else
                            again = 1'b1;
                        phase = ST_NOTE_DOT;
                    end
                    ST_NOTE_DOT:
                    begin
                        if (c == CH_DOT)
                            dotted = 1'b1;
                        else
                            again = 1'b1;
                        phase = ST_NOTE_OCT;
                    end
                    ST_NOTE_OCT:
                        if (is_num(c))
                        begin
                            note_oct = (c >= CH_4 && c <= CH_7) ? 3'(c - CH_0) : dflt_oct;
                            phase    = ST_NOTE_DOT2;
                        end
                        else
                        begin
                            play_note();
                            phase = ST_NOTE_DIV;
                            again = (c != CH_COMMA);
                        end
                    default:
                        if (c == CH_DOT && !dotted)
                            dotted = 1'b1;
                        else
                        begin
                            play_note();
                            phase = ST_NOTE_DIV;
                            again = (c != CH_COMMA);
                        end
                endcase
            end
        end
        if (step_cmds.size() > 0)
            step_cmds[$].last = 1'b1;
        foreach (step_cmds[i])
            tone_cmds_due.push_back(step_cmds[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_tune();
            gap = GAP_RESET;
            tone_cmds_due.delete();
            err_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gap = gap_ms;
            if (out_valid && out_ready)
            begin
                if (tone_cmds_due.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("unexpected tone: hz=%0d ms=%0d last=%0d",
                                 tone_hz, length_ms, last_of_run);
                end
                else
                begin
                    want = tone_cmds_due.pop_front();
                    if (tone_hz !== want.hz || length_ms !== want.ms ||
                        last_of_run !== want.last)
                    begin
                        err_count++;
                        if (err_count <= REPORT_MAX)
                            $display("tone mismatch: expected hz=%0d ms=%0d last=%0d, %s%0d %s%0d %s%0d",
                                     want.hz, want.ms, want.last,
                                     "got hz=", tone_hz, "ms=", length_ms,
                                     "last=", last_of_run);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_byte(text_byte, new_tune);
            pending <= tone_cmds_due.size();
            errors  <= err_count;
        end
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import rts_pkg::*;

    localparam int LIMIT        = 500000;
    localparam int SETTLE       = 40;
    localparam int RANDOM_ITEMS = 1450;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  text_byte = CH_NUL;
    logic        new_tune  = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] tone_hz;
    logic [18:0] length_ms;
    logic        last_of_run;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  gap_ms    = GAP_RESET;

    int          fail_count;
    int          open_count;
    int          idle_in     = 3;
    int          idle_out    = 3;
    int          bytes_sent  = 0;
    int          cycle_count = 0;
    logic [7:0]  tune_bytes[$];

    always #4 clk = ~clk;

    rtttl_tone_sequencer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .new_tune    (new_tune),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tone_hz     (tone_hz),
        .length_ms   (length_ms),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .gap_ms      (gap_ms)
    );

    rtttl_tone_checker tone_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .new_tune    (new_tune),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tone_hz     (tone_hz),
        .length_ms   (length_ms),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .gap_ms      (gap_ms),
        .errors      (fail_count),
        .pending     (open_count)
    );

    task automatic send_byte(input logic [7:0] c, input logic nt);
        int w;
        w = $urandom_range(0, idle_in);
        if (w > 0)
        begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= c;
        new_tune  <= nt;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic nt_first);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], nt_first && i == 0);
    endtask

    task automatic write_gap(input logic [7:0] v);
        cfg_valid <= 1'b1;
        gap_ms    <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // hold the input side until every expected tone has come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (open_count != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic void add_number(input bit musical);
        string digits;
        int v;
        if (musical)
            v = 1 << $urandom_range(0, 5);
        else
            case ($urandom_range(0, 4))
                0: return;
                1: v = $urandom_range(0, 9);
                2: v = $urandom_range(20, 300);
                3: v = 1 << $urandom_range(0, 5);
                default: v = $urandom_range(0, 9999);
            endcase
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++)
            tune_bytes.push_back(digits[i]);
    endfunction

    function automatic void build_tune();
        string letters;
        int n_notes;
        letters = "cdefgabp";
        tune_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(3, 12))
                tune_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3))
            tune_bytes.push_back(8'($urandom_range(CH_A, CH_A + 25)));
        tune_bytes.push_back(CH_COLON);
        if ($urandom_range(0, 3) != 0)
        begin
            tune_bytes.push_back(CH_D);
            tune_bytes.push_back("=");
            add_number(1'b0);
            tune_bytes.push_back(CH_COMMA);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            tune_bytes.push_back(CH_O);
            tune_bytes.push_back("=");
            tune_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
            tune_bytes.push_back(CH_COMMA);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            tune_bytes.push_back(CH_B);
            tune_bytes.push_back("=");
            add_number(1'b0);
            tune_bytes.push_back($urandom_range(0, 1) ? CH_COLON : CH_COMMA);
        end
        n_notes = $urandom_range(1, 6);
        for (int i = 0; i < n_notes; i++)
        begin
            if ($urandom_range(0, 1))
                add_number($urandom_range(0, 3) != 0);
            tune_bytes.push_back(letters[$urandom_range(0, 7)]);
            if ($urandom_range(0, 3) == 0)
                tune_bytes.push_back(CH_SHARP);
            if ($urandom_range(0, 3) == 0)
                tune_bytes.push_back(CH_DOT);
            if ($urandom_range(0, 1))
                tune_bytes.push_back($urandom_range(0, 3) == 0 ?
                                     8'(CH_0 + $urandom_range(0, 9)) :
                                     8'(CH_4 + $urandom_range(0, 3)));
            if ($urandom_range(0, 5) == 0)
                tune_bytes.push_back(CH_DOT);
            if (i != n_notes - 1)
                tune_bytes.push_back(CH_COMMA);
        end
        if ($urandom_range(0, 3) != 0)
            tune_bytes.push_back(CH_NUL);
    endfunction

    task automatic play_tunes(input int items);
        int goal;
        logic [7:0] c;
        logic nt;
        goal = bytes_sent + items;
        while (bytes_sent < goal)
        begin
            build_tune();
            foreach (tune_bytes[i])
            begin
                c = tune_bytes[i];
                if ($urandom_range(0, 19) == 0)
                    c = 8'($urandom_range(0, 255));
                nt = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 63) == 0);
                send_byte(c, nt);
            end
        end
    endtask

    initial
    begin
        int w;
        @(posedge clk);
        forever
        begin
            w = $urandom_range(0, idle_out);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text(":d=0,o=3,b=0,9999b#.7.#9", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_text(":3", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_NUL, 1'b1);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    write_gap(8'd255);
                    idle_in  = 3;
                    idle_out = 3;
                end
                1:
                begin
                    write_gap(8'd0);
                    idle_in  = 0;
                    idle_out = 0;
                end
                2:
                begin
                    write_gap(8'($urandom_range(1, 254)));
                    idle_in  = 0;
                    idle_out = 3;
                end
                default:
                begin
                    write_gap(8'($urandom_range(0, 255)));
                    idle_in  = 3;
                    idle_out = 0;
                end
            endcase
            play_tunes(RANDOM_ITEMS / 8);
            if (p == 0)
                drain();
            play_tunes(RANDOM_ITEMS / 8);
            drain();
        end

        if (fail_count == 0 && open_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> rtttl_tone_sequencer_unit.f
rtl/rts_pkg.sv
rtl/rts_serial_div.sv
rtl/rtttl_tone_sequencer_unit.sv
tb/sv/rtttl_tone_checker.sv
tb/sv/testbench.sv
